// File: hw/rtl/frustum_plane_cull_top_macros.svh
// ----------------------------------------------------------------------------
// Assertion macros for the frustum plane culling block
// Wrappers for concurrent assertions; they expand to nothing in synthesis.
// ----------------------------------------------------------------------------
`ifndef FRUSTUM_PLANE_CULL_TOP_MACROS_SVH
`define FRUSTUM_PLANE_CULL_TOP_MACROS_SVH

`ifndef SYNTHESIS
`define FPC_ASSERT(label, clk, rst_n, prop, msg) \
	label: assert property (@(posedge clk) disable iff (!rst_n) prop) \
		else $error(msg);
`define FPC_ASSERT_NEXT(label, clk, rst_n, ante, cons, msg) \
	label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
		else $error(msg);
`else
`define FPC_ASSERT(label, clk, rst_n, prop, msg)
`define FPC_ASSERT_NEXT(label, clk, rst_n, ante, cons, msg)
`endif

`endif

// File: hw/rtl/fpc_pkg.sv
// ----------------------------------------------------------------------------
// Frustum plane culling package
// Widths, codes, handshake structs and the plane derivation table.
// ----------------------------------------------------------------------------
package fpc_pkg;

	localparam int VALUE_WIDTH = 32;
	localparam int FRAC_BITS = 16;
	localparam int HALF_WIDTH = VALUE_WIDTH - 1;
	localparam int PROD_WIDTH = 2 * VALUE_WIDTH;
	localparam int ACC_WIDTH = PROD_WIDTH + 3;
	localparam int NUM_PLANES = 6;

	typedef logic signed [VALUE_WIDTH-1:0] val_t;

	localparam val_t FIX_ONE = {{(VALUE_WIDTH-FRAC_BITS-1){1'b0}}, 1'b1, {FRAC_BITS{1'b0}}};
	localparam logic [2:0] PLANE_LAST = 3'(NUM_PLANES - 1);
	localparam logic [1:0] TERM_LAST = 2'd3;
	localparam logic [1:0] COL_W = 2'd3;

	typedef enum logic [1:0] {
		ACT_LOAD    = 2'd0,
		ACT_EXTRACT = 2'd1,
		ACT_POINT   = 2'd2,
		ACT_BOX     = 2'd3
	} act_t;

	typedef enum logic [1:0] {
		KIND_ROW    = 2'd0,
		KIND_PLANES = 2'd1,
		KIND_TEST   = 2'd2
	} kind_t;

	typedef struct packed {
		logic vld;
		logic first;
		logic last;
	} mac_ctl_t;

	typedef struct packed {
		logic vld;
		logic neg;
	} mac_res_t;

	function automatic logic [1:0] plane_col(input logic [2:0] p);
		logic [1:0] c;
		case (p)
			3'd0, 3'd1: c = 2'd2;
			3'd2, 3'd3: c = 2'd0;
			default:    c = 2'd1;
		endcase
		return c;
	endfunction

	function automatic logic plane_sub(input logic [2:0] p);
		logic s;
		case (p)
			3'd1, 3'd3, 3'd4: s = 1'b1;
			default:          s = 1'b0;
		endcase
		return s;
	endfunction

	function automatic logic plane_use_w(input logic [2:0] p);
		return p != 3'd0;
	endfunction

	function automatic val_t sat_val(input logic signed [VALUE_WIDTH:0] v);
		val_t r;
		if (v[VALUE_WIDTH] != v[VALUE_WIDTH-1]) begin
			r = v[VALUE_WIDTH] ? {1'b1, {(VALUE_WIDTH-1){1'b0}}}
				: {1'b0, {(VALUE_WIDTH-1){1'b1}}};
		end else begin
			r = v[VALUE_WIDTH-1:0];
		end
		return r;
	endfunction

endpackage

// File: hw/rtl/fpc_mac.sv
// ----------------------------------------------------------------------------
// Shared multiply-accumulate unit
// One signed product per cycle, accumulated exactly; flags the sign of each
// finished dot product.
// ----------------------------------------------------------------------------
`include "frustum_plane_cull_top_macros.svh"

module fpc_mac (
	input  logic              clk,
	input  logic              arst_n,
	input  fpc_pkg::mac_ctl_t ctl,
	input  fpc_pkg::val_t     op_a,
	input  fpc_pkg::val_t     op_b,
	output fpc_pkg::mac_res_t res,
	output logic              busy
);
	import fpc_pkg::*;

	mac_ctl_t                     ctl_s1;
	logic signed [PROD_WIDTH-1:0] prod_s1;
	logic signed [ACC_WIDTH-1:0]  acc_q;
	logic signed [ACC_WIDTH-1:0]  acc_nxt;
	mac_res_t                     res_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			ctl_s1 <= '0;
			res_q  <= '0;
		end else begin
			ctl_s1    <= ctl;
			res_q.vld <= ctl_s1.vld && ctl_s1.last;
			res_q.neg <= acc_nxt[ACC_WIDTH-1];
		end
	end

	always_ff @(posedge clk) begin
		prod_s1 <= PROD_WIDTH'(op_a * op_b);
		if (ctl_s1.vld) begin
			acc_q <= acc_nxt;
		end
	end

	always_comb begin
		acc_nxt = (ctl_s1.first ? '0 : acc_q)
			+ {{(ACC_WIDTH-PROD_WIDTH){prod_s1[PROD_WIDTH-1]}}, prod_s1};
	end

	assign res  = res_q;
	assign busy = ctl_s1.vld || res_q.vld;

	`FPC_ASSERT(a_res_after_last, clk, arst_n, res_q.vld |-> $past(ctl_s1.vld && ctl_s1.last), "MAC result without a closing term")
	`FPC_ASSERT(a_busy_covers_res, clk, arst_n, res_q.vld |-> busy, "MAC result presented while idle")
	`FPC_ASSERT_NEXT(a_last_gives_res, clk, arst_n, ctl_s1.vld && ctl_s1.last, res_q.vld, "Closing term gave no MAC result")

endmodule

// File: hw/rtl/frustum_plane_cull_top.sv
// ----------------------------------------------------------------------------
// Frustum plane culling, top level
// Holds the view-projection matrix and six clip planes and answers point and
// box visibility tests with one shared multiply-accumulate unit.
// ----------------------------------------------------------------------------
// Usage: the input channel carries one command per transfer. A load writes one
// matrix row, an extract derives all six planes from the matrix columns, and a
// point or box test asks whether the item lies within the frustum. Every
// command produces exactly one transfer on the output channel.
// Once a command is taken, a load writes its row, an extract derives one plane
// coefficient per cycle and then lets the pipeline drain, and a point or box test
// runs four multiply-accumulate steps per plane over six planes and then lets the
// pipeline drain.
// A box test uses the corner that lies farthest in front of each plane, so it
// costs the same as a point test.
// The block takes one command at a time; in_stall is high while a command is
// in progress. The finished answer sits in an output register, so the next
// command is taken while the receiver still holds out_stall high; a second
// answer then waits until the first has gone.
// Reset clears both stores to zero, so a test before any extract answers
// inside.
// ----------------------------------------------------------------------------
`include "frustum_plane_cull_top_macros.svh"

module frustum_plane_cull_top (
	input  logic                                clk,
	input  logic                                arst_n,
	input  logic                                in_valid,
	output logic                                in_stall,
	input  logic [1:0]                          action,
	input  logic [1:0]                          row_index,
	input  logic signed [fpc_pkg::VALUE_WIDTH-1:0] coord_x,
	input  logic signed [fpc_pkg::VALUE_WIDTH-1:0] coord_y,
	input  logic signed [fpc_pkg::VALUE_WIDTH-1:0] coord_z,
	input  logic signed [fpc_pkg::VALUE_WIDTH-1:0] coord_w,
	input  logic [fpc_pkg::HALF_WIDTH-1:0]       half_x,
	input  logic [fpc_pkg::HALF_WIDTH-1:0]       half_y,
	input  logic [fpc_pkg::HALF_WIDTH-1:0]       half_z,
	output logic                                out_valid,
	input  logic                                out_stall,
	output logic [1:0]                          kind,
	output logic                                inside_res
);
	import fpc_pkg::*;

	typedef enum logic [5:0] {
		ST_IDLE    = 6'b000001,
		ST_LOAD    = 6'b000010,
		ST_EXTRACT = 6'b000100,
		ST_TEST    = 6'b001000,
		ST_DRAIN   = 6'b010000,
		ST_RESULT  = 6'b100000
	} state_t;

	state_t     state_q;
	act_t       act_q;
	logic [1:0] row_q;
	val_t       ld_q [4];
	val_t       lo_q [3];
	val_t       hi_q [3];
	val_t       lo_d [3];
	val_t       hi_d [3];
	val_t       cin [3];
	logic [HALF_WIDTH-1:0] hin [3];
	logic [2:0] plane_q;
	logic [1:0] term_q;
	logic       inside_q;
	logic       accept;

	val_t       mat_mem [16];
	logic       mat_vld_q [16];
	val_t       mat_a_s1;
	val_t       mat_b_s1;
	logic [3:0] mat_waddr;
	logic [3:0] mat_raddr_a;
	logic [3:0] mat_raddr_b;
	logic       mat_we;

	val_t       pl_mem [24];
	logic       pl_vld_q [24];
	val_t       pl_rd_s1;
	logic [4:0] pl_raddr;
	logic [4:0] pl_waddr;
	logic       pl_we;
	val_t       pl_wdata;
	logic signed [VALUE_WIDTH:0] ext_base;
	logic signed [VALUE_WIDTH:0] ext_v;

	logic       rd_vld_s1;
	logic [2:0] plane_s1;
	logic [1:0] term_s1;

	mac_ctl_t   mac_ctl;
	mac_res_t   mac_res;
	val_t       mac_b;
	logic       mac_busy;

	logic       out_valid_q;
	kind_t      kind_q;
	logic       inside_res_q;
	logic       out_load;
	logic       is_test;

	assign in_stall = state_q != ST_IDLE;
	assign accept   = in_valid && !in_stall;
	assign is_test  = act_q == ACT_POINT || act_q == ACT_BOX;
	assign out_load = state_q == ST_RESULT && (!out_valid_q || !out_stall);

	assign cin = '{coord_x, coord_y, coord_z};
	assign hin = '{half_x, half_y, half_z};

	always_comb begin
		for (int i = 0; i < 3; i++) begin
			if (action == ACT_POINT) begin
				lo_d[i] = cin[i];
				hi_d[i] = cin[i];
			end else begin
				lo_d[i] = sat_val($signed({cin[i][VALUE_WIDTH-1], cin[i]})
					- $signed({2'b00, hin[i]}));
				hi_d[i] = sat_val($signed({cin[i][VALUE_WIDTH-1], cin[i]})
					+ $signed({2'b00, hin[i]}));
			end
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q     <= ST_IDLE;
			plane_q     <= '0;
			term_q      <= '0;
			inside_q    <= 1'b1;
			out_valid_q <= 1'b0;
			rd_vld_s1   <= 1'b0;
		end else begin
			rd_vld_s1 <= state_q == ST_EXTRACT || state_q == ST_TEST;
			if (mac_res.vld && mac_res.neg) begin
				inside_q <= 1'b0;
			end
			if (out_load) begin
				out_valid_q <= 1'b1;
			end else if (!out_stall) begin
				out_valid_q <= 1'b0;
			end
			case (state_q)
				ST_IDLE: begin
					if (accept) begin
						plane_q  <= '0;
						term_q   <= '0;
						inside_q <= 1'b1;
						case (act_t'(action))
							ACT_LOAD:    state_q <= ST_LOAD;
							ACT_EXTRACT: state_q <= ST_EXTRACT;
							default:     state_q <= ST_TEST;
						endcase
					end
				end
				ST_LOAD: begin
					term_q <= term_q + 2'd1;
					if (term_q == TERM_LAST) begin
						state_q <= ST_RESULT;
					end
				end
				ST_EXTRACT, ST_TEST: begin
					term_q <= term_q + 2'd1;
					if (term_q == TERM_LAST) begin
						plane_q <= plane_q + 3'd1;
						if (plane_q == PLANE_LAST) begin
							state_q <= ST_DRAIN;
						end
					end
				end
				ST_DRAIN: begin
					if (!rd_vld_s1 && !mac_busy) begin
						state_q <= ST_RESULT;
					end
				end
				ST_RESULT: begin
					if (out_load) begin
						state_q <= ST_IDLE;
					end
				end
				default: state_q <= ST_IDLE;
			endcase
		end
	end

	always_ff @(posedge clk) begin
		if (accept) begin
			act_q <= act_t'(action);
			row_q <= row_index;
			ld_q  <= '{coord_x, coord_y, coord_z, coord_w};
			lo_q  <= lo_d;
			hi_q  <= hi_d;
		end
		plane_s1 <= plane_q;
		term_s1  <= term_q;
		if (out_load) begin
			if (act_q == ACT_LOAD) begin
				kind_q <= KIND_ROW;
			end else if (act_q == ACT_EXTRACT) begin
				kind_q <= KIND_PLANES;
			end else begin
				kind_q <= KIND_TEST;
			end
			inside_res_q <= is_test && inside_q;
		end
	end

	// Matrix store: entry r*4+c, two registered read ports for the extract.
	assign mat_we      = state_q == ST_LOAD;
	assign mat_waddr   = {row_q, term_q};
	assign mat_raddr_a = {term_q, plane_col(plane_q)};
	assign mat_raddr_b = {term_q, COL_W};

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			for (int i = 0; i < 16; i++) begin
				mat_vld_q[i] <= 1'b0;
			end
		end else if (mat_we) begin
			mat_vld_q[mat_waddr] <= 1'b1;
		end
	end

	always_ff @(posedge clk) begin
		if (mat_we) begin
			mat_mem[mat_waddr] <= ld_q[term_q];
		end
		mat_a_s1 <= mat_vld_q[mat_raddr_a] ? mat_mem[mat_raddr_a] : '0;
		mat_b_s1 <= mat_vld_q[mat_raddr_b] ? mat_mem[mat_raddr_b] : '0;
	end

	// Plane store: plane p holds a, b, c, d at p*4 onward.
	always_comb begin
		ext_v    = {mat_a_s1[VALUE_WIDTH-1], mat_a_s1};
		ext_base = plane_use_w(plane_s1) ? {mat_b_s1[VALUE_WIDTH-1], mat_b_s1} : '0;
		pl_wdata = plane_sub(plane_s1) ? sat_val(ext_base - ext_v)
			: sat_val(ext_base + ext_v);
	end

	assign pl_we    = rd_vld_s1 && act_q == ACT_EXTRACT;
	assign pl_waddr = {plane_s1, term_s1};
	assign pl_raddr = {plane_q, term_q};

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			for (int i = 0; i < 24; i++) begin
				pl_vld_q[i] <= 1'b0;
			end
		end else if (pl_we) begin
			pl_vld_q[pl_waddr] <= 1'b1;
		end
	end

	always_ff @(posedge clk) begin
		if (pl_we) begin
			pl_mem[pl_waddr] <= pl_wdata;
		end
		pl_rd_s1 <= pl_vld_q[pl_raddr] ? pl_mem[pl_raddr] : '0;
	end

	// The corner on the positive side of each coefficient gives the largest
	// distance, so the box is behind a plane only if that corner is.
	always_comb begin
		case (term_s1)
			2'd0:    mac_b = pl_rd_s1[VALUE_WIDTH-1] ? lo_q[0] : hi_q[0];
			2'd1:    mac_b = pl_rd_s1[VALUE_WIDTH-1] ? lo_q[1] : hi_q[1];
			2'd2:    mac_b = pl_rd_s1[VALUE_WIDTH-1] ? lo_q[2] : hi_q[2];
			default: mac_b = FIX_ONE;
		endcase
	end

	assign mac_ctl.vld   = rd_vld_s1 && is_test;
	assign mac_ctl.first = term_s1 == 2'd0;
	assign mac_ctl.last  = term_s1 == TERM_LAST;

	fpc_mac u_mac (
		.clk    (clk),
		.arst_n (arst_n),
		.ctl    (mac_ctl),
		.op_a   (pl_rd_s1),
		.op_b   (mac_b),
		.res    (mac_res),
		.busy   (mac_busy)
	);

	assign out_valid  = out_valid_q;
	assign kind       = kind_q;
	assign inside_res = inside_res_q;

	`FPC_ASSERT(a_out_from_result, clk, arst_n, $rose(out_valid_q) |-> $past(state_q == ST_RESULT), "Output valid rose outside the result state")
	`FPC_ASSERT(a_pipe_empty, clk, arst_n, (state_q == ST_RESULT) |-> (!rd_vld_s1 && !mac_busy), "Result state reached with work in flight")
	`FPC_ASSERT(a_mac_only_test, clk, arst_n, mac_res.vld |-> (act_q == ACT_POINT || act_q == ACT_BOX), "Plane distance produced outside a test")
	`FPC_ASSERT_NEXT(a_result_sent, clk, arst_n, out_load, out_valid_q && state_q == ST_IDLE, "Answer not presented after the result state")

endmodule
